// ----- hw/rtl/swsc_pkg.sv -----
// Package for the steered wheel speed controller.
// Holds payload structs, stage tag structs, datapath widths, the arctangent table
// and the output saturation function. Depends on nothing.
package swsc_pkg;

  // Field and register widths.
  localparam int unsigned RADIUS_W  = 24;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CMD_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd2;

  // Register reset values.
  localparam logic [CFG_W-1:0] BASE_WIDTH_RST = 16'd1000;
  localparam logic [CFG_W-1:0] WHEEL_BASE_RST = 16'd1500;
  localparam logic [CFG_W-1:0] GAIN_RST       = 16'd256;

  // Internal datapath widths.
  localparam int unsigned TWO_R_W = RADIUS_W + 1;  // 2|R|
  localparam int unsigned XY_W    = 58;            // CORDIC x and y
  localparam int unsigned Z_W     = 19;            // CORDIC angle accumulator
  localparam int unsigned THETA_W = 16;            // steer angle, Q2.13
  localparam int unsigned RAD_W   = 64;            // square root radicand
  localparam int unsigned ROOT_W  = 32;            // square root result
  localparam int unsigned VB_W    = 33;            // V * B, signed
  localparam int unsigned NUM_W   = 48;            // divider numerator and quotient
  localparam int unsigned DEN_W   = 32;            // divider denominator, 2|R| * 128
  localparam int unsigned CORR_W  = 34;            // Kp * angle error, signed
  localparam int unsigned RCORR_W = 15;            // rounded correction, signed
  localparam int unsigned SUM_W   = 51;            // wide sum before saturation

  // atan(2^-i) in units of 2^-16 rad, rounded to nearest.
  localparam int unsigned ATAN_N = 24;
  localparam int unsigned ATAN_W = 17;
  localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_N] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
    17'd256,   17'd128,   17'd64,    17'd32,   17'd16,   17'd8,    17'd4,    17'd2,
    17'd1,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,    17'd0
  };

  // One input beat.
  typedef struct packed {
    logic signed [RADIUS_W-1:0] turn_radius;
    logic signed [SPEED_W-1:0]  target_speed;
    logic signed [ANGLE_W-1:0]  front_angle;
    logic signed [ANGLE_W-1:0]  back_angle;
  } swsc_in_t;

  // One output beat.
  typedef struct packed {
    logic signed [CMD_W-1:0] front_right_speed;
    logic signed [CMD_W-1:0] front_left_speed;
    logic signed [CMD_W-1:0] back_right_speed;
    logic signed [CMD_W-1:0] back_left_speed;
  } swsc_out_t;

  // Side data that travels through the CORDIC pipeline.
  typedef struct packed {
    logic                      straight;
    logic                      neg;
    logic signed [SPEED_W-1:0] spd;
    logic signed [ANGLE_W-1:0] thf;
    logic signed [ANGLE_W-1:0] thb;
    logic [TWO_R_W-1:0]        two_r;
    logic signed [VB_W-1:0]    vb;
    logic [RAD_W-1:0]          rad;
  } swsc_cordic_tag_t;

  // Side data that travels through the square root pipeline.
  typedef struct packed {
    logic                      straight;
    logic                      neg;
    logic signed [SPEED_W-1:0] spd;
    logic signed [ANGLE_W-1:0] thf;
    logic signed [ANGLE_W-1:0] thb;
    logic [TWO_R_W-1:0]        two_r;
    logic signed [VB_W-1:0]    vb;
    logic signed [THETA_W-1:0] theta;
  } swsc_sqrt_tag_t;

  // Side data that travels through the divider pipeline.
  typedef struct packed {
    logic                      straight;
    logic signed [SPEED_W-1:0] spd;
    logic                      sgn_c;
    logic                      sgn_a;
    logic signed [CORR_W-1:0]  cf;
    logic signed [CORR_W-1:0]  cb;
  } swsc_div_tag_t;

  // Saturate a wide sum to a wheel speed command.
  function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(8388607);
    lo = SUM_W'(-8388608);
    if (v > hi) begin
      return hi[CMD_W-1:0];
    end else if (v < lo) begin
      return lo[CMD_W-1:0];
    end
    return v[CMD_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/swsc_cordic.sv -----
// Pipelined CORDIC in vectoring mode, one rotation step per register stage.
// Returns the accumulated angle in units of 2^-16 rad. Depends on swsc_pkg.
module swsc_cordic #(
  parameter int unsigned STEPS = 16,
  parameter int unsigned TAG_W = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [swsc_pkg::XY_W-1:0] x_i,
  input  logic signed [swsc_pkg::XY_W-1:0] y_i,
  input  logic [TAG_W-1:0]                 tag_i,
  output logic                             valid_o,
  output logic signed [swsc_pkg::Z_W-1:0]  z_o,
  output logic [TAG_W-1:0]                 tag_o
);

  localparam int unsigned N = (STEPS < swsc_pkg::ATAN_N) ? STEPS : swsc_pkg::ATAN_N;

  logic                            vld [N+1];
  logic signed [swsc_pkg::XY_W-1:0] x  [N+1];
  logic signed [swsc_pkg::XY_W-1:0] y  [N+1];
  logic signed [swsc_pkg::Z_W-1:0]  z  [N+1];
  logic [TAG_W-1:0]                 tg [N+1];

  assign vld[0] = valid_i;
  assign x[0]   = x_i;
  assign y[0]   = y_i;
  assign z[0]   = '0;
  assign tg[0]  = tag_i;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic                             vld_q;
    logic signed [swsc_pkg::XY_W-1:0] x_q, y_q, dx, dy;
    logic signed [swsc_pkg::Z_W-1:0]  z_q, t;
    logic [TAG_W-1:0]                 tg_q;
    logic                             pos;

    assign dx  = y[i] >>> i;
    assign dy  = x[i] >>> i;
    assign t   = swsc_pkg::Z_W'(swsc_pkg::ATAN_TAB[i]);
    assign pos = !y[i][swsc_pkg::XY_W-1] && (y[i] != '0);

    // Valid bit of this step.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[i];
      end
    end

    // Rotate toward the x axis.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tg_q <= tg[i];
        if (pos) begin
          x_q <= x[i] + dx;
          y_q <= y[i] - dy;
          z_q <= z[i] + t;
        end else begin
          x_q <= x[i] - dx;
          y_q <= y[i] + dy;
          z_q <= z[i] - t;
        end
      end
    end

    assign vld[i+1] = vld_q;
    assign x[i+1]   = x_q;
    assign y[i+1]   = y_q;
    assign z[i+1]   = z_q;
    assign tg[i+1]  = tg_q;
  end

  assign valid_o = vld[N];
  assign z_o     = z[N];
  assign tag_o   = tg[N];

endmodule

// ----- hw/rtl/swsc_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Gives floor(sqrt(radicand)). Depends on swsc_pkg.
module swsc_sqrt #(
  parameter int unsigned TAG_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [swsc_pkg::RAD_W-1:0]   rad_i,
  input  logic [TAG_W-1:0]             tag_i,
  output logic                         valid_o,
  output logic [swsc_pkg::ROOT_W-1:0]  root_o,
  output logic [TAG_W-1:0]             tag_o
);

  localparam int unsigned N     = swsc_pkg::ROOT_W;
  localparam int unsigned REM_W = swsc_pkg::ROOT_W + 2;
  localparam int unsigned SH_W  = REM_W + 2;

  logic                          vld  [N+1];
  logic [swsc_pkg::RAD_W-1:0]    rad  [N+1];
  logic [REM_W-1:0]              rem  [N+1];
  logic [swsc_pkg::ROOT_W-1:0]   root [N+1];
  logic [TAG_W-1:0]              tg   [N+1];

  assign vld[0]  = valid_i;
  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign tg[0]   = tag_i;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic                        vld_q;
    logic [swsc_pkg::RAD_W-1:0]  rad_q;
    logic [REM_W-1:0]            rem_q;
    logic [swsc_pkg::ROOT_W-1:0] root_q;
    logic [TAG_W-1:0]            tg_q;
    logic [SH_W-1:0]             sh, trial, diff;
    logic                        ge;

    // Bring down two radicand bits and try the next root bit.
    assign sh    = {rem[i], rad[i][swsc_pkg::RAD_W-1 -: 2]};
    assign trial = {2'b00, root[i], 2'b01};
    assign ge    = sh >= trial;
    assign diff  = sh - trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tg_q   <= tg[i];
        rad_q  <= {rad[i][swsc_pkg::RAD_W-3:0], 2'b00};
        rem_q  <= ge ? diff[REM_W-1:0] : sh[REM_W-1:0];
        root_q <= {root[i][swsc_pkg::ROOT_W-2:0], ge};
      end
    end

    assign vld[i+1]  = vld_q;
    assign rad[i+1]  = rad_q;
    assign rem[i+1]  = rem_q;
    assign root[i+1] = root_q;
    assign tg[i+1]   = tg_q;
  end

  assign valid_o = vld[N];
  assign root_o  = root[N];
  assign tag_o   = tg[N];

endmodule

// ----- hw/rtl/swsc_div.sv -----
// Pipelined two-lane restoring divider, one quotient bit per register stage.
// Both lanes share one denominator. Depends on swsc_pkg.
module swsc_div #(
  parameter int unsigned TAG_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [swsc_pkg::NUM_W-1:0]  num_a_i,
  input  logic [swsc_pkg::NUM_W-1:0]  num_b_i,
  input  logic [swsc_pkg::DEN_W-1:0]  den_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        valid_o,
  output logic [swsc_pkg::NUM_W-1:0]  quo_a_o,
  output logic [swsc_pkg::NUM_W-1:0]  quo_b_o,
  output logic [TAG_W-1:0]            tag_o
);

  localparam int unsigned N    = swsc_pkg::NUM_W;
  localparam int unsigned DW   = swsc_pkg::DEN_W;
  localparam int unsigned SH_W = DW + 1;

  logic                       vld  [N+1];
  logic [swsc_pkg::NUM_W-1:0] nq_a [N+1];
  logic [swsc_pkg::NUM_W-1:0] nq_b [N+1];
  logic [DW-1:0]              rm_a [N+1];
  logic [DW-1:0]              rm_b [N+1];
  logic [DW-1:0]              den  [N+1];
  logic [TAG_W-1:0]           tg   [N+1];

  assign vld[0]  = valid_i;
  assign nq_a[0] = num_a_i;
  assign nq_b[0] = num_b_i;
  assign rm_a[0] = '0;
  assign rm_b[0] = '0;
  assign den[0]  = den_i;
  assign tg[0]   = tag_i;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic                       vld_q;
    logic [swsc_pkg::NUM_W-1:0] nq_a_q, nq_b_q;
    logic [DW-1:0]              rm_a_q, rm_b_q, den_q;
    logic [TAG_W-1:0]           tg_q;
    logic [SH_W-1:0]            sh_a, sh_b, dx, df_a, df_b;
    logic                       ge_a, ge_b;

    // Shift in the next numerator bit and subtract where it fits.
    assign dx   = {1'b0, den[i]};
    assign sh_a = {rm_a[i], nq_a[i][swsc_pkg::NUM_W-1]};
    assign sh_b = {rm_b[i], nq_b[i][swsc_pkg::NUM_W-1]};
    assign ge_a = sh_a >= dx;
    assign ge_b = sh_b >= dx;
    assign df_a = sh_a - dx;
    assign df_b = sh_b - dx;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tg_q   <= tg[i];
        den_q  <= den[i];
        rm_a_q <= ge_a ? df_a[DW-1:0] : sh_a[DW-1:0];
        rm_b_q <= ge_b ? df_b[DW-1:0] : sh_b[DW-1:0];
        nq_a_q <= {nq_a[i][swsc_pkg::NUM_W-2:0], ge_a};
        nq_b_q <= {nq_b[i][swsc_pkg::NUM_W-2:0], ge_b};
      end
    end

    assign vld[i+1]  = vld_q;
    assign nq_a[i+1] = nq_a_q;
    assign nq_b[i+1] = nq_b_q;
    assign rm_a[i+1] = rm_a_q;
    assign rm_b[i+1] = rm_b_q;
    assign den[i+1]  = den_q;
    assign tg[i+1]   = tg_q;
  end

  assign valid_o = vld[N];
  assign quo_a_o = nq_a[N];
  assign quo_b_o = nq_b[N];
  assign tag_o   = tg[N];

endmodule

// ----- hw/rtl/steered_wheel_speed_controller.sv -----
// Steered wheel speed controller: four wheel speed commands per control tick.
// The CORDIC, square root and divider take one step, root bit or quotient bit per
// stage. Throughput is one beat per cycle unless the skid entry is occupied; a
// two-entry output buffer absorbs one stall.
// Reset clears all valid bits and loads the register defaults. Uses swsc_pkg.
module steered_wheel_speed_controller #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  swsc_pkg::swsc_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output swsc_pkg::swsc_out_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [swsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [swsc_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int unsigned CT_W = $bits(swsc_pkg::swsc_cordic_tag_t);
  localparam int unsigned ST_W = $bits(swsc_pkg::swsc_sqrt_tag_t);
  localparam int unsigned DT_W = $bits(swsc_pkg::swsc_div_tag_t);

  // Configuration registers.
  logic [swsc_pkg::CFG_W-1:0] base_width_q, wheel_base_q, gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_width_q <= swsc_pkg::BASE_WIDTH_RST;
      wheel_base_q <= swsc_pkg::WHEEL_BASE_RST;
      gain_q       <= swsc_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swsc_pkg::REG_BASE_WIDTH: base_width_q <= cfg_wdata_i;
        swsc_pkg::REG_WHEEL_BASE: wheel_base_q <= cfg_wdata_i;
        swsc_pkg::REG_GAIN:       gain_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the skid entry is occupied.
  logic skid_vld_q;
  logic en;
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // Stage 1: radius magnitude and sign.
  logic                                s1_vld_q, s1_neg_q, s1_straight_q;
  logic [swsc_pkg::RADIUS_W-1:0]       s1_ar_q;
  logic signed [swsc_pkg::SPEED_W-1:0] s1_spd_q;
  logic signed [swsc_pkg::ANGLE_W-1:0] s1_thf_q, s1_thb_q;
  logic [swsc_pkg::RADIUS_W-1:0]       in_r_neg;

  assign in_r_neg = swsc_pkg::RADIUS_W'(-in_data_i.turn_radius);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_neg_q      <= in_data_i.turn_radius[swsc_pkg::RADIUS_W-1];
      s1_straight_q <= (in_data_i.turn_radius == '0);
      s1_ar_q       <= in_data_i.turn_radius[swsc_pkg::RADIUS_W-1] ? in_r_neg
                                                                    : in_data_i.turn_radius;
      s1_spd_q      <= in_data_i.target_speed;
      s1_thf_q      <= in_data_i.front_angle;
      s1_thb_q      <= in_data_i.back_angle;
    end
  end

  // Stage 2: squares for the hypotenuse and the V*B product.
  logic                                s2_vld_q, s2_neg_q, s2_straight_q;
  logic [swsc_pkg::TWO_R_W-1:0]        s2_two_r_q, s1_two_r;
  logic [2*swsc_pkg::TWO_R_W-1:0]      s2_sqr_q;
  logic [2*swsc_pkg::CFG_W-1:0]        s2_sql_q;
  logic signed [swsc_pkg::VB_W-1:0]    s2_vb_q, s1_vb;
  logic signed [swsc_pkg::SPEED_W-1:0] s2_spd_q;
  logic signed [swsc_pkg::ANGLE_W-1:0] s2_thf_q, s2_thb_q;

  assign s1_two_r = {s1_ar_q, 1'b0};
  assign s1_vb    = swsc_pkg::VB_W'(s1_spd_q) * $signed({1'b0, base_width_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_neg_q      <= s1_neg_q;
      s2_straight_q <= s1_straight_q;
      s2_two_r_q    <= s1_two_r;
      s2_sqr_q      <= s1_two_r * s1_two_r;
      s2_sql_q      <= wheel_base_q * wheel_base_q;
      s2_vb_q       <= s1_vb;
      s2_spd_q      <= s1_spd_q;
      s2_thf_q      <= s1_thf_q;
      s2_thb_q      <= s1_thb_q;
    end
  end

  // CORDIC on (2|R|, L) gives the steer angle magnitude.
  swsc_pkg::swsc_cordic_tag_t         ct_in, ct_out;
  logic signed [swsc_pkg::XY_W-1:0]   c_x, c_y;
  logic                               c_vld;
  logic signed [swsc_pkg::Z_W-1:0]    c_z;
  logic [CT_W-1:0]                    ct_out_bits;

  assign c_x = swsc_pkg::XY_W'({s2_two_r_q, 30'b0});
  assign c_y = swsc_pkg::XY_W'({wheel_base_q, 30'b0});

  always_comb begin
    ct_in.straight = s2_straight_q;
    ct_in.neg      = s2_neg_q;
    ct_in.spd      = s2_spd_q;
    ct_in.thf      = s2_thf_q;
    ct_in.thb      = s2_thb_q;
    ct_in.two_r    = s2_two_r_q;
    ct_in.vb       = s2_vb_q;
    ct_in.rad      = (swsc_pkg::RAD_W'(s2_sqr_q) + swsc_pkg::RAD_W'(s2_sql_q)) << 14;
  end

  swsc_cordic #(
    .STEPS (CORDIC_STEPS),
    .TAG_W (CT_W)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_vld_q),
    .x_i     (c_x),
    .y_i     (c_y),
    .tag_i   (ct_in),
    .valid_o (c_vld),
    .z_o     (c_z),
    .tag_o   (ct_out_bits)
  );

  assign ct_out = ct_out_bits;

  // Round the angle to Q2.13 and apply the radius sign.
  logic signed [swsc_pkg::Z_W-1:0]     z_rnd, z_sh;
  logic signed [swsc_pkg::THETA_W-1:0] theta_abs;
  swsc_pkg::swsc_sqrt_tag_t            st_in, st_out;
  logic [ST_W-1:0]                     st_out_bits;
  logic                                q_vld;
  logic [swsc_pkg::ROOT_W-1:0]         q_root;

  assign z_rnd     = c_z + swsc_pkg::Z_W'(4);
  assign z_sh      = z_rnd >>> 3;
  assign theta_abs = z_sh[swsc_pkg::THETA_W-1:0];

  always_comb begin
    st_in.straight = ct_out.straight;
    st_in.neg      = ct_out.neg;
    st_in.spd      = ct_out.spd;
    st_in.thf      = ct_out.thf;
    st_in.thb      = ct_out.thb;
    st_in.two_r    = ct_out.two_r;
    st_in.vb       = ct_out.vb;
    st_in.theta    = ct_out.neg ? -theta_abs : theta_abs;
  end

  // Square root of (4R^2 + L^2) * 2^14.
  swsc_sqrt #(
    .TAG_W (ST_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_vld),
    .rad_i   (ct_out.rad),
    .tag_i   (st_in),
    .valid_o (q_vld),
    .root_o  (q_root),
    .tag_o   (st_out_bits)
  );

  assign st_out = st_out_bits;

  // Multiply stage: numerator magnitudes, divider denominator, angle corrections.
  logic                                m_vld_q, m_straight_q, m_sgn_c_q, m_sgn_a_q;
  logic [swsc_pkg::NUM_W-1:0]          m_mag_c_q;
  logic [swsc_pkg::DEN_W+6:0]          m_mag_a_q;
  logic [swsc_pkg::DEN_W-1:0]          m_den_q;
  logic signed [swsc_pkg::CORR_W-1:0]  m_cf_q, m_cb_q;
  logic signed [swsc_pkg::SPEED_W-1:0] m_spd_q;
  logic [swsc_pkg::SPEED_W-1:0]        abs_v;
  logic [swsc_pkg::VB_W-1:0]           vb_neg;
  logic [swsc_pkg::DEN_W-1:0]          abs_vb;
  logic signed [swsc_pkg::ANGLE_W:0]   err_f, err_b;
  logic signed [swsc_pkg::CFG_W:0]     kp;

  assign abs_v  = st_out.spd[swsc_pkg::SPEED_W-1] ? swsc_pkg::SPEED_W'(-st_out.spd)
                                                  : st_out.spd;
  assign vb_neg = swsc_pkg::VB_W'(-st_out.vb);
  assign abs_vb = st_out.vb[swsc_pkg::VB_W-1] ? vb_neg[swsc_pkg::DEN_W-1:0]
                                              : st_out.vb[swsc_pkg::DEN_W-1:0];
  assign err_f  = (swsc_pkg::ANGLE_W+1)'(st_out.thf) - (swsc_pkg::ANGLE_W+1)'(st_out.theta);
  assign err_b  = (swsc_pkg::ANGLE_W+1)'(st_out.theta) + (swsc_pkg::ANGLE_W+1)'(st_out.thb);
  assign kp     = $signed({1'b0, gain_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_straight_q <= st_out.straight;
      m_spd_q      <= st_out.spd;
      m_sgn_c_q    <= st_out.spd[swsc_pkg::SPEED_W-1];
      m_sgn_a_q    <= st_out.vb[swsc_pkg::VB_W-1] ^ st_out.neg;
      m_mag_c_q    <= abs_v * q_root;
      m_mag_a_q    <= {abs_vb, 7'b0};
      m_den_q      <= swsc_pkg::DEN_W'({st_out.two_r, 7'b0});
      m_cf_q       <= kp * err_f;
      m_cb_q       <= kp * err_b;
    end
  end

  // Divide both numerators (with half the divisor added) by 2|R| * 128.
  swsc_pkg::swsc_div_tag_t    dt_in, dt_out;
  logic [DT_W-1:0]            dt_out_bits;
  logic [swsc_pkg::NUM_W-1:0] half_den, num_c, num_a, quo_c, quo_a;
  logic                       d_vld;

  assign half_den = swsc_pkg::NUM_W'(m_den_q >> 1);
  assign num_c    = m_mag_c_q + half_den;
  assign num_a    = swsc_pkg::NUM_W'(m_mag_a_q) + half_den;

  always_comb begin
    dt_in.straight = m_straight_q;
    dt_in.spd      = m_spd_q;
    dt_in.sgn_c    = m_sgn_c_q;
    dt_in.sgn_a    = m_sgn_a_q;
    dt_in.cf       = m_cf_q;
    dt_in.cb       = m_cb_q;
  end

  swsc_div #(
    .TAG_W (DT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_vld_q),
    .num_a_i (num_c),
    .num_b_i (num_a),
    .den_i   (m_den_q),
    .tag_i   (dt_in),
    .valid_o (d_vld),
    .quo_a_o (quo_c),
    .quo_b_o (quo_a),
    .tag_o   (dt_out_bits)
  );

  assign dt_out = dt_out_bits;

  // Sign stage: signed common and side terms, rounded corrections.
  logic                                 f_vld_q, f_straight_q;
  logic signed [swsc_pkg::NUM_W:0]      f_com_q, f_adj_q, com_pos, adj_pos;
  logic signed [swsc_pkg::RCORR_W-1:0]  f_corf_q, f_corb_q, corf, corb;
  logic signed [swsc_pkg::SPEED_W-1:0]  f_spd_q;
  logic [swsc_pkg::CORR_W-1:0]          cf_mag, cb_mag, cf_rnd, cb_rnd;
  logic [swsc_pkg::CORR_W-1:0]          cf_neg, cb_neg;

  assign com_pos = $signed({1'b0, quo_c});
  assign adj_pos = $signed({1'b0, quo_a});
  assign cf_neg  = swsc_pkg::CORR_W'(-dt_out.cf);
  assign cb_neg  = swsc_pkg::CORR_W'(-dt_out.cb);
  assign cf_mag  = dt_out.cf[swsc_pkg::CORR_W-1] ? cf_neg : dt_out.cf;
  assign cb_mag  = dt_out.cb[swsc_pkg::CORR_W-1] ? cb_neg : dt_out.cb;
  assign cf_rnd  = (cf_mag + swsc_pkg::CORR_W'(1 << 20)) >> 21;
  assign cb_rnd  = (cb_mag + swsc_pkg::CORR_W'(1 << 20)) >> 21;
  assign corf    = dt_out.cf[swsc_pkg::CORR_W-1]
                   ? -$signed(cf_rnd[swsc_pkg::RCORR_W-1:0])
                   : $signed(cf_rnd[swsc_pkg::RCORR_W-1:0]);
  assign corb    = dt_out.cb[swsc_pkg::CORR_W-1]
                   ? -$signed(cb_rnd[swsc_pkg::RCORR_W-1:0])
                   : $signed(cb_rnd[swsc_pkg::RCORR_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_straight_q <= dt_out.straight;
      f_spd_q      <= dt_out.spd;
      f_com_q      <= dt_out.sgn_c ? -com_pos : com_pos;
      f_adj_q      <= dt_out.sgn_a ? -adj_pos : adj_pos;
      f_corf_q     <= corf;
      f_corb_q     <= corb;
    end
  end

  // Wheel sums and saturation.
  logic signed [swsc_pkg::SUM_W-1:0] com_w, adj_w, corf_w, corb_w;
  swsc_pkg::swsc_out_t               res;

  assign com_w  = swsc_pkg::SUM_W'(f_com_q);
  assign adj_w  = swsc_pkg::SUM_W'(f_adj_q);
  assign corf_w = swsc_pkg::SUM_W'(f_corf_q);
  assign corb_w = swsc_pkg::SUM_W'(f_corb_q);

  always_comb begin
    if (f_straight_q) begin
      res.front_right_speed = swsc_pkg::CMD_W'(f_spd_q);
      res.front_left_speed  = swsc_pkg::CMD_W'(f_spd_q);
      res.back_right_speed  = swsc_pkg::CMD_W'(f_spd_q);
      res.back_left_speed   = swsc_pkg::CMD_W'(f_spd_q);
    end else begin
      res.front_right_speed = swsc_pkg::sat_cmd(com_w + adj_w - corf_w);
      res.front_left_speed  = swsc_pkg::sat_cmd(com_w - adj_w + corf_w);
      res.back_right_speed  = swsc_pkg::sat_cmd(com_w + adj_w - corb_w);
      res.back_left_speed   = swsc_pkg::sat_cmd(com_w - adj_w + corb_w);
    end
  end

  // Output register with one skid entry behind it.
  logic                out_vld_q, take;
  swsc_pkg::swsc_out_t out_data_q, skid_data_q;

  assign take = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (f_vld_q) begin
      if (!out_vld_q || take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_data_q <= skid_data_q;
      end
    end else if (f_vld_q) begin
      if (!out_vld_q || take) begin
        out_data_q <= res;
      end else begin
        skid_data_q <= res;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- dv/tb_steered_wheel_speed_controller.sv -----
// Testbench for the steered wheel speed controller: directed and random control ticks
// checked against an in-bench fixed point predictor of the four wheel speed commands.
// Depends on swsc_pkg and the steered_wheel_speed_controller RTL.
module tb_steered_wheel_speed_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS = 16;
  localparam int unsigned PIPE_LAT = STEPS + 85;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  swsc_pkg::swsc_in_t in_data;
  logic out_valid;
  logic out_stall;
  swsc_pkg::swsc_out_t out_data;
  logic cfg_we;
  logic [swsc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [swsc_pkg::CFG_W-1:0] cfg_wdata;

  // Predictor copy of the register file.
  longint track_mm;
  longint axle_mm;
  longint kp_q8;

  swsc_pkg::swsc_out_t cmd_queue[$];
  int unsigned err_cnt;
  int unsigned beat_cnt;
  int unsigned ticks_sent;
  int unsigned turn_ticks;
  longint cycle_cnt;
  bit quiet_mode;

  steered_wheel_speed_controller #(.CORDIC_STEPS(STEPS)) DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Round to nearest with halves away from zero; den is positive.
  function automatic longint div_near(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic signed [swsc_pkg::CMD_W-1:0] clamp24(longint v);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[swsc_pkg::CMD_W-1:0];
  endfunction

  // Steer angle atan(L / 2|R|) in Q2.13 by vectoring rotation.
  function automatic longint steer_angle(longint two_r, longint l);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = two_r <<< 30;
    y = l <<< 30;
    z = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(swsc_pkg::ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(swsc_pkg::ATAN_TAB[i]);
      end
    end
    return (z + 4) >>> 3;
  endfunction

  function automatic swsc_pkg::swsc_out_t wheel_cmds(swsc_pkg::swsc_in_t t);
    swsc_pkg::swsc_out_t o;
    longint r, v, tf, tb, two_r, theta, h, common, side, cf, cb;
    r = longint'(t.turn_radius);
    v = longint'(t.target_speed);
    tf = longint'(t.front_angle);
    tb = longint'(t.back_angle);
    if (r == 0) begin
      o.front_right_speed = clamp24(v);
      o.front_left_speed = clamp24(v);
      o.back_right_speed = clamp24(v);
      o.back_left_speed = clamp24(v);
      return o;
    end
    two_r = 2 * ((r < 0) ? -r : r);
    theta = steer_angle(two_r, axle_mm);
    if (r < 0) theta = -theta;
    h = int_sqrt(longint'(two_r * two_r + axle_mm * axle_mm) << 14);
    common = div_near(v * h, two_r * 128);
    side = div_near(v * track_mm, two_r);
    if (r < 0) side = -side;
    cf = div_near(kp_q8 * (tf - theta), longint'(1) << 21);
    cb = div_near(kp_q8 * (theta + tb), longint'(1) << 21);
    o.front_right_speed = clamp24(common + side - cf);
    o.front_left_speed = clamp24(common - side + cf);
    o.back_right_speed = clamp24(common + side - cb);
    o.back_left_speed = clamp24(common - side + cb);
    return o;
  endfunction

  // Idle decision: roughly 31 in a hundred, none in quiet mode.
  function automatic bit want_idle();
    return !quiet_mode && ($urandom_range(99) < 31);
  endfunction

  // Receiver: random stall and result check on every accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      cycle_cnt <= 0;
      beat_cnt <= 0;
      err_cnt = 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      out_stall <= want_idle();
      if (out_valid && !out_stall) begin
        beat_cnt <= beat_cnt + 1;
        if (cmd_queue.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat expected=none actual=%h", $time, out_data);
        end else begin
          swsc_pkg::swsc_out_t e;
          e = cmd_queue.pop_front();
          if (e.front_right_speed !== out_data.front_right_speed) begin
            err_cnt++;
            $display("%0t: front_right_speed expected=%0d actual=%0d", $time,
                     e.front_right_speed, out_data.front_right_speed);
          end
          if (e.front_left_speed !== out_data.front_left_speed) begin
            err_cnt++;
            $display("%0t: front_left_speed expected=%0d actual=%0d", $time,
                     e.front_left_speed, out_data.front_left_speed);
          end
          if (e.back_right_speed !== out_data.back_right_speed) begin
            err_cnt++;
            $display("%0t: back_right_speed expected=%0d actual=%0d", $time,
                     e.back_right_speed, out_data.back_right_speed);
          end
          if (e.back_left_speed !== out_data.back_left_speed) begin
            err_cnt++;
            $display("%0t: back_left_speed expected=%0d actual=%0d", $time,
                     e.back_left_speed, out_data.back_left_speed);
          end
        end
      end
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Send one tick, with a random number of idle cycles before it.
  // Valid stays high after the beat so back to back ticks leave no gap.
  task automatic send_tick(swsc_pkg::swsc_in_t t);
    if (want_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (want_idle()) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cmd_queue.push_back(wheel_cmds(t));
    ticks_sent++;
    if (t.turn_radius != 0) turn_ticks++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  // Register write while the pipeline is empty.
  task automatic write_reg(logic [swsc_pkg::CFG_IDX_W-1:0] idx,
                           logic [swsc_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      swsc_pkg::REG_BASE_WIDTH: track_mm = val;
      swsc_pkg::REG_WHEEL_BASE: axle_mm = val;
      swsc_pkg::REG_GAIN: kp_q8 = val;
      default: ;
    endcase
  endtask

  function automatic swsc_pkg::swsc_in_t mk_tick(int r, int v, int f, int b);
    swsc_pkg::swsc_in_t t;
    t.turn_radius = r[swsc_pkg::RADIUS_W-1:0];
    t.target_speed = v[swsc_pkg::SPEED_W-1:0];
    t.front_angle = f[swsc_pkg::ANGLE_W-1:0];
    t.back_angle = b[swsc_pkg::ANGLE_W-1:0];
    return t;
  endfunction

  function automatic int rand_radius();
    case ($urandom_range(5))
      0: return 0;
      1: return $urandom_range(1, 20) * (($urandom_range(1)) ? 1 : -1);
      2: return int'($urandom_range(1, 8388607)) * (($urandom_range(1)) ? 1 : -1);
      3: return ($urandom_range(1)) ? 8388607 : -8388608;
      default: return int'($urandom_range(100, 20000)) * (($urandom_range(1)) ? 1 : -1);
    endcase
  endfunction

  // Field extremes, straight driving, both turn directions.
  task automatic test_directed();
    send_tick(mk_tick(0, 32767, 100, -100));
    send_tick(mk_tick(0, -32768, 0, 0));
    send_tick(mk_tick(0, 0, 32767, -32768));
    send_tick(mk_tick(1, 32767, 32767, 32767));
    send_tick(mk_tick(-1, -32768, -32768, -32768));
    send_tick(mk_tick(1, -32768, -32768, 32767));
    send_tick(mk_tick(8388607, 32767, 0, 0));
    send_tick(mk_tick(-8388608, -32768, 0, 0));
    send_tick(mk_tick(2000, 1000, 2000, -2000));
    send_tick(mk_tick(-2000, 1000, -2000, 2000));
    send_tick(mk_tick(-1, 32767, 32767, -32768));
    send_tick(mk_tick(750, 500, 0, 0));
    send_tick(mk_tick(-750, -500, 100, 100));
    send_tick(mk_tick(5, 0, 32767, 32767));
  endtask

  // Register extremes including zero width, base and gain.
  task automatic test_register_corners();
    drain();
    write_reg(swsc_pkg::REG_BASE_WIDTH, 16'd0);
    write_reg(swsc_pkg::REG_WHEEL_BASE, 16'd0);
    write_reg(swsc_pkg::REG_GAIN, 16'd0);
    test_directed();
    drain();
    write_reg(swsc_pkg::REG_BASE_WIDTH, 16'hFFFF);
    write_reg(swsc_pkg::REG_WHEEL_BASE, 16'hFFFF);
    write_reg(swsc_pkg::REG_GAIN, 16'hFFFF);
    test_directed();
    drain();
    write_reg(swsc_pkg::REG_BASE_WIDTH, 16'd1);
    write_reg(swsc_pkg::REG_WHEEL_BASE, 16'd1);
    write_reg(swsc_pkg::REG_GAIN, 16'd1);
    test_directed();
  endtask

  // Random ticks over several register settings, one phase without idling.
  task automatic test_random(int n);
    swsc_pkg::swsc_in_t t;
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(swsc_pkg::REG_BASE_WIDTH, swsc_pkg::CFG_W'($urandom_range(0, 65535)));
      write_reg(swsc_pkg::REG_WHEEL_BASE, swsc_pkg::CFG_W'($urandom_range(0, 65535)));
      write_reg(swsc_pkg::REG_GAIN, swsc_pkg::CFG_W'($urandom_range(0, 65535)));
      quiet_mode = (ph == 2);
      for (int i = 0; i < n; i++) begin
        t = mk_tick(rand_radius(), $urandom, $urandom, $urandom);
        send_tick(t);
        // Let the pipeline empty once mid phase.
        if (ph == 1 && i == n / 2) drain();
      end
      quiet_mode = 1'b0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = swsc_pkg::REG_BASE_WIDTH;
    cfg_wdata = '0;
    ticks_sent = 0;
    turn_ticks = 0;
    quiet_mode = 1'b0;
    track_mm = swsc_pkg::BASE_WIDTH_RST;
    axle_mm = swsc_pkg::WHEEL_BASE_RST;
    kp_q8 = swsc_pkg::GAIN_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_corners();
    test_random(260);
    drain();

    $display("Covered %0d ticks (%0d turning) and %0d result beats,", ticks_sent,
             turn_ticks, beat_cnt);
    $display("with register extremes and random settings under random stalls.");
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
